FILE: rtl/core/roulette_wheel_selector_macros.svh
// Assertion macros shared by the roulette wheel selector modules.
// Needs nothing else; each module that checks itself includes this header.
`ifndef ROULETTE_WHEEL_SELECTOR_MACROS_SVH
`define ROULETTE_WHEEL_SELECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RWS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rws_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the roulette wheel selector.
// Used by the controller, the datapath and the top level; depends on nothing.
package rws_pkg;

    localparam int unsigned SLOT_W = 8;
    localparam int unsigned PICK_W = 8;

    typedef enum logic [1:0] {
        RD_SLOT = 2'd0,
        RD_EXCL = 2'd1,
        RD_SCAN = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    clear_step;
        logic    capture;
        t_rd_sel rd_sel;
        logic    ld_commit;
        logic    den_load;
        logic    mul_step;
        logic    scan_init;
        logic    scan_step;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic den_zero;
        logic mul_done;
        logic scan_hit;
        logic scan_end;
    } t_status;

endpackage

FILE: rtl/core/roulette_wheel_selector.sv
`timescale 1ns / 1ps
// Top level of the roulette wheel selector: joins the controller and the datapath.
// Depends on rws_pkg, rws_controller and rws_datapath.

// A transfer is taken when start is high and busy is low. A load (func 0) writes one
// score and its running total; a slot at or beyond POP_MAX is ignored. A select
// (func 1) reads the excluded score, multiplies the draw by the denominator one bit per
// cycle, then scans the score memory through its single read port one entry per cycle;
// when the denominator is zero it skips both steps. Each select gives exactly one result,
// shown for one cycle with o_valid high; the receiver cannot stall, so it must take the
// result in that cycle.
// After reset the block clears every entry of the score memory with busy held high.
module roulette_wheel_selector #(
    parameter int unsigned POP_MAX    = 256,
    parameter int unsigned SCORE_BITS = 16,
    parameter int unsigned DRAW_BITS  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_func,
    input  logic [rws_pkg::SLOT_W-1:0] i_slot,
    input  logic [SCORE_BITS-1:0]      i_fitness,
    input  logic [DRAW_BITS-1:0]       i_draw,
    output logic                       o_valid,
    output logic [rws_pkg::PICK_W-1:0] o_picked,
    output logic                       o_found
);

    rws_pkg::t_cmd    cmd;
    rws_pkg::t_status status;

    rws_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (i_func),
        .o_busy   (busy),
        .o_cmd    (cmd),
        .i_status (status)
    );

    rws_datapath #(
        .POP_MAX    (POP_MAX),
        .SCORE_BITS (SCORE_BITS),
        .DRAW_BITS  (DRAW_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_status  (status),
        .i_slot    (i_slot),
        .i_fitness (i_fitness),
        .i_draw    (i_draw),
        .o_valid   (o_valid),
        .o_picked  (o_picked),
        .o_found   (o_found)
    );

endmodule

FILE: rtl/core/rws_datapath.sv
`timescale 1ns / 1ps
// Datapath of the roulette wheel selector: score memory, running total, pair state,
// bit-serial multiplier and scan accumulator. Depends on rws_pkg and the macro header.
`include "roulette_wheel_selector_macros.svh"

module rws_datapath #(
    parameter int unsigned POP_MAX    = 256,
    parameter int unsigned SCORE_BITS = 16,
    parameter int unsigned DRAW_BITS  = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rws_pkg::t_cmd             i_cmd,
    output rws_pkg::t_status          o_status,
    input  logic [rws_pkg::SLOT_W-1:0] i_slot,
    input  logic [SCORE_BITS-1:0]     i_fitness,
    input  logic [DRAW_BITS-1:0]      i_draw,
    output logic                      o_valid,
    output logic [rws_pkg::PICK_W-1:0] o_picked,
    output logic                      o_found
);

    localparam int unsigned IDX_W  = $clog2(POP_MAX);
    localparam int unsigned CNT_W  = $clog2(POP_MAX + 1);
    localparam int unsigned TOT_W  = SCORE_BITS + IDX_W;
    localparam int unsigned PROD_W = TOT_W + DRAW_BITS;
    localparam int unsigned MCNT_W = $clog2(DRAW_BITS + 1);

    logic [SCORE_BITS-1:0]     r_mem [POP_MAX];
    logic [SCORE_BITS-1:0]     r_rd_data;
    logic [IDX_W-1:0]          rd_addr;
    logic [IDX_W-1:0]          wr_addr;
    logic [SCORE_BITS-1:0]     wr_data;
    logic                      wr_en;

    logic [rws_pkg::SLOT_W-1:0] r_slot;
    logic [SCORE_BITS-1:0]     r_fit;
    logic [DRAW_BITS-1:0]      r_draw;
    logic [IDX_W-1:0]          slot_idx;
    logic                      slot_ok;

    logic [IDX_W-1:0]          r_clr_idx;
    logic [TOT_W-1:0]          r_total;
    logic [TOT_W-1:0]          n_total;
    logic                      r_pending;
    logic [IDX_W-1:0]          r_excl;

    logic [TOT_W-1:0]          r_denom;
    logic [TOT_W-1:0]          n_denom;
    logic [PROD_W-1:0]         r_prod;
    logic [DRAW_BITS-1:0]      r_mdraw;
    logic [MCNT_W-1:0]         r_mul_left;

    logic [CNT_W-1:0]          r_addr;
    logic                      r_dvld;
    logic [IDX_W-1:0]          r_didx;
    logic [TOT_W-1:0]          r_acc;
    logic [TOT_W-1:0]          n_acc;
    logic                      skip;
    logic                      hit;
    logic                      last;

    logic                      r_valid;
    logic                      r_found;
    logic [rws_pkg::PICK_W-1:0] r_picked;

    assign slot_idx = IDX_W'(r_slot);
    assign slot_ok  = 32'(r_slot) < 32'(POP_MAX);

    always_comb begin
        case (i_cmd.rd_sel)
            rws_pkg::RD_SLOT: rd_addr = slot_idx;
            rws_pkg::RD_EXCL: rd_addr = r_excl;
            rws_pkg::RD_SCAN: rd_addr = r_addr[IDX_W-1:0];
            default:          rd_addr = slot_idx;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot_idx;
        wr_data = r_fit;
        if (i_cmd.clear_step) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_idx;
            wr_data = '0;
        end else if (i_cmd.ld_commit && slot_ok) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign n_total = r_total - TOT_W'(r_rd_data) + TOT_W'(r_fit);
    assign n_denom = r_total - (r_pending ? TOT_W'(r_rd_data) : '0);

    assign skip  = r_pending && (r_didx == r_excl);
    assign n_acc = r_acc + (skip ? '0 : TOT_W'(r_rd_data));
    assign hit   = r_dvld && !skip && ({n_acc, {DRAW_BITS{1'b0}}} > r_prod);
    assign last  = r_dvld && (r_didx == IDX_W'(POP_MAX - 1));

    always_comb begin
        o_status.clear_last = r_clr_idx == IDX_W'(POP_MAX - 1);
        o_status.den_zero   = n_denom == '0;
        o_status.mul_done   = r_mul_left == MCNT_W'(1);
        o_status.scan_hit   = hit;
        o_status.scan_end   = last;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_slot <= i_slot;
            r_fit  <= i_fitness;
            r_draw <= i_draw;
        end
        if (i_cmd.den_load) begin
            r_denom <= n_denom;
            r_prod  <= '0;
            r_mdraw <= r_draw;
        end else if (i_cmd.mul_step) begin
            r_prod  <= (r_prod << 1) + (r_mdraw[DRAW_BITS-1] ? PROD_W'(r_denom) : '0);
            r_mdraw <= r_mdraw << 1;
        end
        if (i_cmd.scan_init) begin
            r_acc <= '0;
        end else if (i_cmd.scan_step && r_dvld) begin
            r_acc <= n_acc;
        end
        if (i_cmd.scan_step && (r_addr != CNT_W'(POP_MAX))) begin
            r_didx <= r_addr[IDX_W-1:0];
        end
        if (i_cmd.den_load && o_status.den_zero) begin
            r_found  <= 1'b0;
            r_picked <= '0;
        end else if (i_cmd.scan_step && (hit || last)) begin
            r_found  <= hit;
            r_picked <= hit ? rws_pkg::PICK_W'(r_didx) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_total    <= '0;
            r_pending  <= 1'b0;
            r_excl     <= '0;
            r_mul_left <= '0;
            r_addr     <= '0;
            r_dvld     <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= (i_cmd.den_load && o_status.den_zero)
                    || (i_cmd.scan_step && (hit || last));
            if (i_cmd.clear_step) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.ld_commit && slot_ok) begin
                r_total <= n_total;
            end
            if (i_cmd.scan_step && hit) begin
                if (r_pending) begin
                    r_pending <= 1'b0;
                end else begin
                    r_pending <= 1'b1;
                    r_excl    <= r_didx;
                end
            end
            if (i_cmd.den_load) begin
                r_mul_left <= MCNT_W'(DRAW_BITS);
            end else if (i_cmd.mul_step) begin
                r_mul_left <= r_mul_left - 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_addr <= '0;
                r_dvld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (r_addr != CNT_W'(POP_MAX)) begin
                    r_addr <= r_addr + 1'b1;
                    r_dvld <= 1'b1;
                end else begin
                    r_dvld <= 1'b0;
                end
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_found  = r_found;
    assign o_picked = r_picked;

    `RWS_ASSERT_NXT(a_valid_pulse, i_clk, i_rst_n, r_valid, !r_valid, "result strobe held for two cycles")
    `RWS_ASSERT_IMP(a_found_denom, i_clk, i_rst_n, r_valid && r_found, r_denom != '0, "pick reported with zero denominator")
    `RWS_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n, 1'b1, r_addr <= CNT_W'(POP_MAX), "scan address beyond the table")

endmodule

FILE: rtl/core/rws_controller.sv
`timescale 1ns / 1ps
// Controller of the roulette wheel selector: sequences clearing, loads and selects.
// Depends on rws_pkg and the macro header.
`include "roulette_wheel_selector_macros.svh"

module rws_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_func,
    output logic             o_busy,
    output rws_pkg::t_cmd    o_cmd,
    input  rws_pkg::t_status i_status
);

    typedef enum logic [7:0] {
        ST_CLEAR   = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_LD_RD   = 8'b0000_0100,
        ST_LD_WR   = 8'b0000_1000,
        ST_SEL_RD  = 8'b0001_0000,
        ST_SEL_DEN = 8'b0010_0000,
        ST_MUL     = 8'b0100_0000,
        ST_SCAN    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = rws_pkg::RD_SLOT;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_func ? ST_SEL_RD : ST_LD_RD;
                end
            end
            ST_LD_RD: begin
                o_cmd.rd_sel = rws_pkg::RD_SLOT;
                n_state = ST_LD_WR;
            end
            ST_LD_WR: begin
                o_cmd.ld_commit = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SEL_RD: begin
                o_cmd.rd_sel = rws_pkg::RD_EXCL;
                n_state = ST_SEL_DEN;
            end
            ST_SEL_DEN: begin
                o_cmd.den_load = 1'b1;
                n_state = i_status.den_zero ? ST_IDLE : ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.mul_done) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.rd_sel    = rws_pkg::RD_SCAN;
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_hit || i_status.scan_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != ST_IDLE;

    `RWS_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "accepted transfer did not raise busy")
    `RWS_ASSERT_IMP(a_clear_busy, i_clk, i_rst_n, $rose(i_rst_n), o_busy, "clearing pass not under way after reset")

endmodule

FILE: tb/sv/roulette_wheel_selector_checker.sv
`timescale 1ns / 1ps
// Function codes shared by the testbench, and the checker of the roulette wheel selector.
// Depends on rws_pkg; watches the block's ports, predicts every pick and compares it.
package rws_tb_pkg;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

endpackage

module roulette_wheel_selector_checker #(
    parameter int unsigned POP_MAX    = 256,
    parameter int unsigned SCORE_BITS = 16,
    parameter int unsigned DRAW_BITS  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       i_func,
    input  logic [rws_pkg::SLOT_W-1:0] i_slot,
    input  logic [SCORE_BITS-1:0]      i_fitness,
    input  logic [DRAW_BITS-1:0]       i_draw,
    input  logic                       o_valid,
    input  logic [rws_pkg::PICK_W-1:0] o_picked,
    input  logic                       o_found,
    output int                         fail_count,
    output int                         pending_count
);

    localparam int unsigned TOTAL_W = SCORE_BITS + $clog2(POP_MAX);
    localparam int unsigned PROD_W  = TOTAL_W + DRAW_BITS;

    typedef struct packed {
        logic [rws_pkg::PICK_W-1:0] picked;
        logic                       found;
    } t_pick;

    logic [SCORE_BITS-1:0]      score_copy [POP_MAX];
    logic [TOTAL_W-1:0]         total_copy;
    logic                       pair_open;
    logic [rws_pkg::SLOT_W-1:0] skip_slot;
    t_pick                      pick_queue [$];
    t_pick                      oldest_pick;
    t_pick                      fresh_pick;
    int                         mismatch_tally = 0;

    assign fail_count = mismatch_tally;

    function automatic t_pick spin_wheel(input logic [DRAW_BITS-1:0] draw);
        logic [TOTAL_W-1:0] denom;
        logic [TOTAL_W-1:0] running;
        logic [PROD_W-1:0]  threshold;
        t_pick              pick;
        pick = '0;
        denom = total_copy - (pair_open ? TOTAL_W'(score_copy[skip_slot]) : TOTAL_W'(0));
        if (denom == '0) return pick;
        threshold = PROD_W'(draw) * PROD_W'(denom);
        running = '0;
        for (int idx = 0; idx < POP_MAX; idx++) begin
            if (pair_open && idx == int'(skip_slot)) continue;
            running = running + TOTAL_W'(score_copy[idx]);
            if ({running, DRAW_BITS'(0)} > threshold) begin
                pick.picked = rws_pkg::PICK_W'(idx);
                pick.found  = 1'b1;
                if (pair_open) begin
                    pair_open = 1'b0;
                end else begin
                    pair_open = 1'b1;
                    skip_slot = rws_pkg::SLOT_W'(idx);
                end
                return pick;
            end
        end
        return pick;
    endfunction

    task automatic note_mismatch(input string what, input t_pick wanted);
        if (mismatch_tally < 10) begin
            $display("%0t ns: %s: expected picked=%0d found=%0b, got picked=%0d found=%0b",
                     $time, what, wanted.picked, wanted.found, o_picked, o_found);
        end
        mismatch_tally++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int idx = 0; idx < POP_MAX; idx++) score_copy[idx] = '0;
            total_copy = '0;
            pair_open  = 1'b0;
            skip_slot  = '0;
        end else begin
            if (o_valid) begin
                if (pick_queue.size() == 0) begin
                    note_mismatch("result with no transfer waiting", t_pick'(0));
                end else begin
                    oldest_pick = pick_queue.pop_front();
                    if (oldest_pick.picked !== o_picked || oldest_pick.found !== o_found)
                        note_mismatch("wrong pick", oldest_pick);
                end
            end
            if (start && !busy) begin
                if (i_func == rws_tb_pkg::FUNC_SELECT) begin
                    fresh_pick = spin_wheel(i_draw);
                    pick_queue = {pick_queue, fresh_pick};
                end else if (int'(i_slot) < POP_MAX) begin
                    total_copy = total_copy - TOTAL_W'(score_copy[i_slot])
                                 + TOTAL_W'(i_fitness);
                    score_copy[i_slot] = i_fitness;
                end
            end
        end
        pending_count <= pick_queue.size();
    end

endmodule

FILE: tb/sv/roulette_wheel_selector_tb.sv
`timescale 1ns / 1ps
// Top of the roulette wheel selector testbench: clock, reset, stimulus and verdict.
// Depends on rws_pkg, rws_tb_pkg, roulette_wheel_selector and its checker.
module roulette_wheel_selector_tb;

    localparam int unsigned POP_MAX        = 256;
    localparam int unsigned SCORE_BITS     = 16;
    localparam int unsigned DRAW_BITS      = 16;
    localparam int unsigned ITEM_COUNT     = 1350;
    localparam int unsigned CALM_TAIL      = 200;
    localparam int unsigned DRAIN_CYCLES   = 300;
    localparam int unsigned WATCHDOG_LIMIT = 3000;

    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       start     = 1'b0;
    logic                       i_func    = rws_tb_pkg::FUNC_LOAD;
    logic [rws_pkg::SLOT_W-1:0] i_slot    = '0;
    logic [SCORE_BITS-1:0]      i_fitness = '0;
    logic [DRAW_BITS-1:0]       i_draw    = '0;
    logic                       busy;
    logic                       o_valid;
    logic [rws_pkg::PICK_W-1:0] o_picked;
    logic                       o_found;
    int                         fail_count;
    int                         pending_count;
    int                         quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    roulette_wheel_selector #(
        .POP_MAX(POP_MAX), .SCORE_BITS(SCORE_BITS), .DRAW_BITS(DRAW_BITS)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_slot(i_slot), .i_fitness(i_fitness), .i_draw(i_draw),
        .o_valid(o_valid), .o_picked(o_picked), .o_found(o_found)
    );

    roulette_wheel_selector_checker #(
        .POP_MAX(POP_MAX), .SCORE_BITS(SCORE_BITS), .DRAW_BITS(DRAW_BITS)
    ) checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_slot(i_slot), .i_fitness(i_fitness), .i_draw(i_draw),
        .o_valid(o_valid), .o_picked(o_picked), .o_found(o_found),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    task automatic send_item(input logic func, input logic [rws_pkg::SLOT_W-1:0] slot,
                             input logic [SCORE_BITS-1:0] fitness,
                             input logic [DRAW_BITS-1:0] draw);
        @(negedge i_clk);
        start     <= 1'b1;
        i_func    <= func;
        i_slot    <= slot;
        i_fitness <= fitness;
        i_draw    <= draw;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic rest(input int unsigned cycles);
        @(negedge i_clk);
        start     <= 1'b0;
        i_func    <= 1'($urandom);
        i_slot    <= rws_pkg::SLOT_W'($urandom);
        i_fitness <= SCORE_BITS'($urandom);
        i_draw    <= DRAW_BITS'($urandom);
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_valid) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [rws_pkg::SLOT_W-1:0] slot;
        logic [SCORE_BITS-1:0]      fitness;
        logic [DRAW_BITS-1:0]       draw;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table first, so the denominator is zero.
        send_item(rws_tb_pkg::FUNC_SELECT, 8'd0, 16'h0000, 16'h0000);
        send_item(rws_tb_pkg::FUNC_SELECT, 8'd255, 16'hFFFF, 16'hFFFF);
        send_item(rws_tb_pkg::FUNC_LOAD, 8'd0, 16'hFFFF, 16'h0000);
        send_item(rws_tb_pkg::FUNC_SELECT, 8'd0, 16'h0000, 16'h0000);
        // Only the excluded slot holds a score, so the second pick finds nothing.
        send_item(rws_tb_pkg::FUNC_SELECT, 8'd0, 16'h0000, 16'hFFFF);
        send_item(rws_tb_pkg::FUNC_LOAD, 8'd255, 16'h0001, 16'hFFFF);
        send_item(rws_tb_pkg::FUNC_SELECT, 8'd17, 16'h1234, 16'hFFFF);
        send_item(rws_tb_pkg::FUNC_LOAD, 8'd128, 16'h0000, 16'h0000);
        send_item(rws_tb_pkg::FUNC_SELECT, 8'd0, 16'h0000, 16'h0000);
        // A load during a pair changes the score of the excluded slot.
        send_item(rws_tb_pkg::FUNC_LOAD, 8'd0, 16'h0003, 16'h0000);
        send_item(rws_tb_pkg::FUNC_SELECT, 8'd0, 16'h0000, 16'h8000);
        send_item(rws_tb_pkg::FUNC_LOAD, 8'd7, 16'hAAAA, 16'h5555);
        send_item(rws_tb_pkg::FUNC_LOAD, 8'd8, 16'h5555, 16'hAAAA);
        send_item(rws_tb_pkg::FUNC_SELECT, 8'hAA, 16'hAAAA, 16'h5555);
        send_item(rws_tb_pkg::FUNC_SELECT, 8'h55, 16'h5555, 16'hAAAA);
        send_item(rws_tb_pkg::FUNC_SELECT, 8'd0, 16'h0000, 16'hFFFF);
        send_item(rws_tb_pkg::FUNC_LOAD, 8'd255, 16'h0000, 16'h0000);
        send_item(rws_tb_pkg::FUNC_LOAD, 8'd0, 16'h0000, 16'h0000);
        send_item(rws_tb_pkg::FUNC_SELECT, 8'd0, 16'h0000, 16'h0000);
        send_item(rws_tb_pkg::FUNC_SELECT, 8'd0, 16'h0000, 16'hFFFF);
        send_item(rws_tb_pkg::FUNC_SELECT, 8'd0, 16'h0000, 16'h8000);

        for (int n = 0; n < ITEM_COUNT; n++) begin
            if (n < ITEM_COUNT - CALM_TAIL && $urandom_range(0, 4) == 0)
                rest($urandom_range(1, 19));
            if ($urandom_range(0, 9) < 4) begin
                case ($urandom_range(0, 9))
                    0: draw = '0;
                    1: draw = '1;
                    default: draw = DRAW_BITS'($urandom);
                endcase
                send_item(rws_tb_pkg::FUNC_SELECT, rws_pkg::SLOT_W'($urandom),
                          SCORE_BITS'($urandom), draw);
            end else begin
                if ($urandom_range(0, 1) == 0) slot = rws_pkg::SLOT_W'($urandom_range(0, 15));
                else slot = rws_pkg::SLOT_W'($urandom);
                case ($urandom_range(0, 7))
                    0, 1: fitness = '0;
                    2: fitness = '1;
                    3: fitness = SCORE_BITS'($urandom_range(1, 15));
                    default: fitness = SCORE_BITS'($urandom);
                endcase
                send_item(rws_tb_pkg::FUNC_LOAD, slot, fitness, DRAW_BITS'($urandom));
            end
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
